/* design/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

	localparam int QueueDepth = 4;
	localparam int QueueAw    = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [5:0] BlockLast  = 6'd63;
	localparam logic [5:0] LenPos     = 6'd56;
	localparam logic [5:0] RoundLast  = 6'd63;
	localparam logic [4:0] DigestLast = 5'd31;
	localparam logic [7:0] PadMark    = 8'h80;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} st_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

/* design/sha_in_if.sv */
// Input channel: message beats carrying kind and data byte.
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source(output valid, output kind, output data_byte, input ready);
	modport sink(input valid, input kind, input data_byte, output ready);
endinterface

/* design/sha_out_if.sv */
// Output channel: digest beats carrying one byte and a last flag.
interface sha_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] digest_byte;
	logic       last_byte;

	modport source(output valid, output digest_byte, output last_byte, input ready);
	modport sink(input valid, input digest_byte, input last_byte, output ready);
endinterface

/* design/sha_queue.sv */
// Front end: accepts message beats into a short queue for the hashing engine.
module sha_queue (
	input  logic           clk,
	input  logic           arst_n,
	sha_in_if.sink         msg,
	output sha_pkg::item_t item,
	output logic           item_valid,
	input  logic           item_pop
);
	import sha_pkg::*;

	item_t                mem_q [QueueDepth];
	logic [QueueAw-1:0]   wr_q;
	logic [QueueAw-1:0]   rd_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign msg.ready  = (cnt_q != QueueCntW'(QueueDepth));
	assign push       = msg.valid && msg.ready;
	assign item_valid = (cnt_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{kind: msg.kind, data_byte: msg.data_byte};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QueueCntW'(QueueDepth))
		else $error("queue count beyond depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QueueCntW'(QueueDepth) && !item_pop) |=> !msg.ready)
		else $error("queue full but ready raised without a pop");

endmodule

/* design/sha_engine.sv */
// Back end: block assembly, padding, 64-round compression and digest output.
module sha_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_pop,
	sha_out_if.source      digest
);
	import sha_pkg::*;

	st_t          state_q;
	st_t          state_d;
	logic [60:0]  count_q;
	logic [5:0]   rnd_q;
	logic [4:0]   oidx_q;
	logic         pad_busy_q;
	logic         len_ok_q;
	logic         final_q;
	logic [31:0]  chain_q [8];
	logic [31:0]  v_q [8];
	logic [511:0] blk_q;
	logic [63:0]  len_q;
	logic         ovalid_q;
	logic [7:0]   obyte_q;
	logic         olast_q;

	logic [5:0]   pos;
	logic         shift_en;
	logic [7:0]   shift_byte;
	logic         go_rounds;
	logic         fin_start;
	logic         out_load;
	logic         len_phase;
	logic [31:0]  w0;
	logic [31:0]  w1;
	logic [31:0]  w9;
	logic [31:0]  w14;
	logic [31:0]  wnew;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  ch;
	logic [31:0]  maj;
	logic [31:0]  sel_word;
	logic [31:0]  sel_shift;

	assign pos       = count_q[5:0];
	assign len_phase = (pos >= LenPos) && len_ok_q;

	assign w0   = blk_q[511:480];
	assign w1   = blk_q[479:448];
	assign w9   = blk_q[223:192];
	assign w14  = blk_q[63:32];
	assign wnew = ssig1(w14) + w9 + ssig0(w1) + w0;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bsig1(v_q[4]) + ch + RoundK[rnd_q] + w0;
	assign t2  = bsig0(v_q[0]) + maj;

	assign sel_word  = chain_q[oidx_q[4:2]];
	assign sel_shift = sel_word >> {~oidx_q[1:0], 3'b000};

	assign digest.valid       = ovalid_q;
	assign digest.digest_byte = obyte_q;
	assign digest.last_byte   = olast_q;

	always_comb begin
		state_d    = state_q;
		item_pop   = 1'b0;
		shift_en   = 1'b0;
		shift_byte = '0;
		go_rounds  = 1'b0;
		fin_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					shift_en = 1'b1;
					if (item.kind == KIND_DATA) begin
						shift_byte = item.data_byte;
					end else begin
						shift_byte = PadMark;
						fin_start  = 1'b1;
						state_d    = ST_PAD;
					end
					if (pos == BlockLast) begin
						go_rounds = 1'b1;
						state_d   = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				shift_en   = 1'b1;
				shift_byte = len_phase ? len_q[63:56] : 8'h00;
				if (pos == BlockLast) begin
					go_rounds = 1'b1;
					state_d   = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == RoundLast) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (pad_busy_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				out_load = !ovalid_q || digest.ready;
				if (out_load && oidx_q == DigestLast) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rnd_q      <= '0;
			oidx_q     <= '0;
			pad_busy_q <= 1'b0;
			len_ok_q   <= 1'b0;
			final_q    <= 1'b0;
			ovalid_q   <= 1'b0;
			chain_q    <= InitH;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				count_q <= count_q + 1'b1;
			end
			if (fin_start) begin
				pad_busy_q <= 1'b1;
				len_ok_q   <= (pos < LenPos) || (pos == BlockLast);
			end
			if (go_rounds) begin
				final_q <= (state_q == ST_PAD) && len_ok_q;
				if (state_q == ST_PAD) begin
					len_ok_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
				oidx_q   <= oidx_q + 1'b1;
				if (oidx_q == DigestLast) begin
					chain_q    <= InitH;
					count_q    <= '0;
					pad_busy_q <= 1'b0;
					len_ok_q   <= 1'b0;
					final_q    <= 1'b0;
				end
			end else if (digest.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], wnew};
		end
		if (go_rounds) begin
			v_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (fin_start) begin
			len_q <= {count_q, 3'b000};
		end else if (state_q == ST_PAD && len_phase) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (out_load) begin
			obyte_q <= sel_shift[7:0];
			olast_q <= (oidx_q == DigestLast);
		end
	end

	a_rnd_rest: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ROUND |-> rnd_q == '0)
		else $error("round counter not at rest outside compression");

	a_out_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> pad_busy_q && len_ok_q)
		else $error("digest output without a finished message");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && oidx_q == DigestLast) |=>
			(count_q == '0 && state_q == ST_IDLE && olast_q))
		else $error("message state not cleared after last digest beat");

endmodule

/* design/sha256_stream_hasher_top.sv */
// Top level of the SHA-256 byte stream hasher.
// Absorb: a data beat enters the 4-entry queue and is absorbed while the engine is idle;
// every 64th byte starts a compression: 64 rounds on one round unit plus the chaining add.
// Finish: the pad mark and zero bytes up to the block end, then a compression; from pos 56
// up, one more pad block and a second compression. The add leads to ST_OUT, which loads
// the digest into the output register. Throughput: 32 digest beats, one per cycle when the
// sink is ready. Reset (arst_n low) empties the queue, loads InitH, zeroes the count.
module sha256_stream_hasher_top (
	input  logic      clk,
	input  logic      arst_n,
	sha_in_if.sink    msg,
	sha_out_if.source digest
);
	import sha_pkg::*;

	item_t item;
	logic  item_valid;
	logic  item_pop;

	sha_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	sha_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.digest     (digest)
	);

endmodule

/* verif/sha256_stream_hasher_top_tb.sv */
// Self-checking testbench for the byte-serial SHA-256 stream hasher.
module sha256_stream_hasher_top_tb;
	import sha_pkg::*;

	localparam int ItemTarget = 320;
	localparam int LongHold   = 400;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} digest_beat_t;

	typedef struct {
		kind_t        kind;
		logic [7:0]   payload;
		bit           typed;
		logic [255:0] digest;
	} hash_row_t;

	localparam logic [31:0] HashIv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int PadLens [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 121, 128};

	localparam logic [255:0] EmptyDigest =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] AbcDigest =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	hash_row_t script [14] = '{
		'{KIND_FINISH, 8'h00, 1'b1, EmptyDigest},
		'{KIND_DATA,   8'h61, 1'b0, '0},
		'{KIND_DATA,   8'h62, 1'b0, '0},
		'{KIND_DATA,   8'h63, 1'b0, '0},
		'{KIND_FINISH, 8'hff, 1'b1, AbcDigest},
		'{KIND_DATA,   8'h00, 1'b0, '0},
		'{KIND_DATA,   8'hff, 1'b0, '0},
		'{KIND_DATA,   8'h80, 1'b0, '0},
		'{KIND_DATA,   8'h7f, 1'b0, '0},
		'{KIND_FINISH, 8'h5a, 1'b0, '0},
		'{KIND_FINISH, 8'ha5, 1'b1, EmptyDigest},
		'{KIND_DATA,   8'h01, 1'b0, '0},
		'{KIND_DATA,   8'hfe, 1'b0, '0},
		'{KIND_FINISH, 8'h00, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	sha_in_if  msg_ch();
	sha_out_if digest_ch();

	sha256_stream_hasher_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	logic [31:0]  chain [8];
	logic [7:0]   blk [64];
	logic [60:0]  msg_len;
	digest_beat_t digest_due [$];
	digest_beat_t want_beat;
	int           bad_beats;
	int           beats_in;
	bit           calm;
	bit           sender_gaps;
	bit           long_hold_done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, ch, maj, t1, t2;
		int r;
		for (r = 0; r < 16; r++) begin
			w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
		end
		for (r = 16; r < 64; r++) begin
			s0 = rotr(w[r - 15], 7) ^ rotr(w[r - 15], 18) ^ (w[r - 15] >> 3);
			s1 = rotr(w[r - 2], 17) ^ rotr(w[r - 2], 19) ^ (w[r - 2] >> 10);
			w[r] = s1 + w[r - 7] + s0 + w[r - 16];
		end
		for (r = 0; r < 8; r++) begin
			v[r] = chain[r];
		end
		for (r = 0; r < 64; r++) begin
			s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + RoundConst[r] + w[r];
			s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (r = 0; r < 8; r++) begin
			chain[r] = chain[r] + v[r];
		end
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		logic [5:0] pos;
		pos = msg_len[5:0];
		blk[pos] = b;
		msg_len = msg_len + 61'd1;
		if (pos == 6'd63) begin
			compress_block();
		end
	endfunction

	function automatic logic [255:0] finish_message();
		logic [63:0]  bitlen;
		logic [255:0] sum;
		int pos;
		int i;
		bitlen = {msg_len, 3'b000};
		pos = msg_len[5:0];
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (i = 0; i < 8; i++) begin
			blk[56 + i] = bitlen[63 - 8 * i -: 8];
		end
		compress_block();
		sum = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
		chain = HashIv;
		msg_len = '0;
		return sum;
	endfunction

	task automatic send_beat(input kind_t kind, input logic [7:0] payload, input bit typed,
			input logic [255:0] typed_digest);
		int gap;
		logic [255:0] sum;
		if (sender_gaps && !calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			msg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.kind <= kind;
		msg_ch.data_byte <= payload;
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
		beats_in++;
		if (kind == KIND_DATA) begin
			absorb_byte(payload);
		end else begin
			sum = finish_message();
			if (typed) begin
				sum = typed_digest;
			end
			for (int i = 0; i < 32; i++) begin
				digest_due.push_back('{sum[255 - 8 * i -: 8], i == 31});
			end
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && digest_ch.valid && digest_ch.ready) begin
			if (digest_due.size() == 0) begin
				$display("%0t: unexpected digest beat: expected none, actual %h last %b",
					$time, digest_ch.digest_byte, digest_ch.last_byte);
				bad_beats++;
			end else begin
				want_beat = digest_due.pop_front();
				if (digest_ch.digest_byte !== want_beat.value) begin
					$display("%0t: digest_byte mismatch: expected %h, actual %h",
						$time, want_beat.value, digest_ch.digest_byte);
					bad_beats++;
				end
				if (digest_ch.last_byte !== want_beat.last) begin
					$display("%0t: last_byte mismatch: expected %b, actual %b",
						$time, want_beat.last, digest_ch.last_byte);
					bad_beats++;
				end
			end
		end
	end

	initial begin
		digest_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!long_hold_done && beats_in > 120 && digest_ch.valid) begin
				digest_ch.ready <= 1'b0;
				repeat (LongHold) @(negedge clk);
				long_hold_done = 1'b1;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				digest_ch.ready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 30)) @(negedge clk);
			end else begin
				digest_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
		end
	end

	initial begin
		#(12 * 1500000);
		$display("sha256_stream_hasher_top test failed");
		$finish;
	end

	initial begin
		int len;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.kind = KIND_DATA;
		msg_ch.data_byte = 8'h00;
		chain = HashIv;
		msg_len = '0;
		bad_beats = 0;
		beats_in = 0;
		calm = 1'b0;
		sender_gaps = 1'b1;
		long_hold_done = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			send_beat(script[i].kind, script[i].payload, script[i].typed, script[i].digest);
		end

		while (beats_in < ItemTarget) begin
			sender_gaps = ($urandom_range(0, 2) != 0);
			if (beats_in > ItemTarget * 7 / 8) begin
				calm = 1'b1;
			end
			if ($urandom_range(0, 9) < 4) begin
				len = PadLens[$urandom_range(0, 11)];
			end else begin
				len = $urandom_range(0, 24);
			end
			repeat (len) send_beat(KIND_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
			send_beat(KIND_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
		end
		msg_ch.valid <= 1'b0;
		calm = 1'b1;

		while (digest_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (digest_due.size() != 0) begin
			$display("%0t: %0d digest beats still expected", $time, digest_due.size());
			bad_beats++;
		end
		if (bad_beats == 0) begin
			$display("sha256_stream_hasher_top test passed");
		end else begin
			$display("sha256_stream_hasher_top test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
design/sha_pkg.sv
design/sha_in_if.sv
design/sha_out_if.sv
design/sha_queue.sv
design/sha_engine.sv
design/sha256_stream_hasher_top.sv
verif/sha256_stream_hasher_top_tb.sv
